@@ hw/rtl/tcpq_pkg.sv @@
// shared types and constants for the three-class priority queue
package tcpq_pkg;

    localparam int CLASS_DEPTH_DEF = 16;
    localparam int NUM_CLASSES     = 3;
    localparam int VALUE_W         = 8;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 8;

    localparam logic [VALUE_W-1:0] HIGH_THR_RESET = 8'd50;
    localparam logic [VALUE_W-1:0] MID_THR_RESET  = 8'd30;

    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MID_THR  = 1'b1;

    typedef enum logic
    {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } mode_t;

    typedef enum logic [1:0]
    {
        CLASS_HIGH = 2'd0,
        CLASS_MID  = 2'd1,
        CLASS_LOW  = 2'd2
    } class_t;

    typedef enum logic [1:0]
    {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed
    {
        mode_t               mode;
        class_t              cls;
        logic [VALUE_W-1:0]  value;
    } cmd_t;

endpackage

@@ hw/rtl/tcpq_ifs.sv @@
// request and response channel interfaces
interface tcpq_req_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] priority_value;

    modport source (output valid, output mode, output priority_value, input ready);
    modport sink   (input valid, input mode, input priority_value, output ready);
endinterface

interface tcpq_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] removed_value;
    logic [1:0] status;

    modport source (output valid, output removed_value, output status, input ready);
    modport sink   (input valid, input removed_value, input status, output ready);
endinterface

@@ hw/rtl/tcpq_front.sv @@
// front end: threshold registers and class selection of incoming requests
module tcpq_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tcpq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcpq_pkg::CFG_DATA_W-1:0]     cfg_data,
    tcpq_req_if.sink                            req,
    output logic                                push_valid,
    input  logic                                push_ready,
    output tcpq_pkg::cmd_t                      push_cmd
);

    logic [tcpq_pkg::VALUE_W-1:0] high_thr_reg;
    logic [tcpq_pkg::VALUE_W-1:0] mid_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_thr_reg <= tcpq_pkg::HIGH_THR_RESET;
            mid_thr_reg  <= tcpq_pkg::MID_THR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tcpq_pkg::REG_HIGH_THR: high_thr_reg <= cfg_data;
                tcpq_pkg::REG_MID_THR:  mid_thr_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        push_cmd.mode  = tcpq_pkg::mode_t'(req.mode);
        push_cmd.value = req.priority_value;
        if (req.priority_value >= high_thr_reg)
        begin
            push_cmd.cls = tcpq_pkg::CLASS_HIGH;
        end
        else if (req.priority_value >= mid_thr_reg)
        begin
            push_cmd.cls = tcpq_pkg::CLASS_MID;
        end
        else
        begin
            push_cmd.cls = tcpq_pkg::CLASS_LOW;
        end
    end

    assign push_valid = req.valid;
    assign req.ready  = push_ready;

endmodule

@@ hw/rtl/tcpq_cmd_fifo.sv @@
// two-entry command queue between front end and back end
module tcpq_cmd_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  tcpq_pkg::cmd_t  push_cmd,
    output logic            pop_valid,
    input  logic            pop_ready,
    output tcpq_pkg::cmd_t  pop_cmd
);

    tcpq_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hw/rtl/tcpq_back.sv @@
// back end: class stores, pointers and counts, result register
module tcpq_back
#(
    parameter int CLASS_DEPTH = tcpq_pkg::CLASS_DEPTH_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  tcpq_pkg::cmd_t  cmd,
    tcpq_rsp_if.source      rsp
);

    localparam int PW = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
    localparam int CW = $clog2(CLASS_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int MEM_DEPTH = tcpq_pkg::NUM_CLASSES * CLASS_DEPTH;
    localparam int AW = $clog2(MEM_DEPTH);
    localparam int NC = tcpq_pkg::NUM_CLASSES;

    typedef enum logic
    {
        S_RUN  = 1'b0,
        S_READ = 1'b1
    } state_t;

    state_t                         state_reg, state_next;
    logic [PW-1:0]                  rp_reg [NC];
    logic [PW-1:0]                  rp_next [NC];
    logic [CW-1:0]                  cnt_reg [NC];
    logic [CW-1:0]                  cnt_next [NC];
    logic                           out_valid_reg, out_valid_next;
    logic [tcpq_pkg::VALUE_W-1:0]   out_value_reg, out_value_next;
    tcpq_pkg::status_t              out_status_reg, out_status_next;

    logic [tcpq_pkg::VALUE_W-1:0]   mem [MEM_DEPTH];
    logic [tcpq_pkg::VALUE_W-1:0]   rd_data_reg;
    logic                           mem_we;
    logic                           mem_re;
    logic [AW-1:0]                  mem_waddr;
    logic [AW-1:0]                  mem_raddr;

    logic                           fire;
    logic                           out_free;
    logic [1:0]                     ins_idx;
    logic [1:0]                     rem_idx;
    logic                           any_held;
    logic [SW-1:0]                  slot_sum;
    logic [PW-1:0]                  wr_slot;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd_ready = (state_reg == S_RUN) && out_free;
    assign fire      = cmd_valid && cmd_ready;

    always_comb
    begin
        case (cmd.cls)
            tcpq_pkg::CLASS_HIGH: ins_idx = 2'd0;
            tcpq_pkg::CLASS_MID:  ins_idx = 2'd1;
            default:              ins_idx = 2'd2;
        endcase
    end

    always_comb
    begin
        any_held = 1'b1;
        if (cnt_reg[0] != '0)
        begin
            rem_idx = 2'd0;
        end
        else if (cnt_reg[1] != '0)
        begin
            rem_idx = 2'd1;
        end
        else
        begin
            rem_idx  = 2'd2;
            any_held = (cnt_reg[2] != '0);
        end
    end

    assign slot_sum = SW'(rp_reg[ins_idx]) + SW'(cnt_reg[ins_idx]);
    assign wr_slot  = (slot_sum >= SW'(CLASS_DEPTH)) ? PW'(slot_sum - SW'(CLASS_DEPTH))
                                                     : PW'(slot_sum);
    assign mem_waddr = AW'(AW'(ins_idx) * AW'(CLASS_DEPTH) + AW'(wr_slot));
    assign mem_raddr = AW'(AW'(rem_idx) * AW'(CLASS_DEPTH) + AW'(rp_reg[rem_idx]));

    always_comb
    begin
        state_next      = state_reg;
        rp_next         = rp_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        case (state_reg)
            S_RUN:
            begin
                if (fire)
                begin
                    if (cmd.mode == tcpq_pkg::MODE_INSERT)
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = '0;
                        if (cnt_reg[ins_idx] == CW'(CLASS_DEPTH))
                        begin
                            out_status_next = tcpq_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            out_status_next   = tcpq_pkg::STATUS_DONE;
                            mem_we            = 1'b1;
                            cnt_next[ins_idx] = cnt_reg[ins_idx] + CW'(1);
                        end
                    end
                    else if (!any_held)
                    begin
                        out_valid_next  = 1'b1;
                        out_value_next  = '0;
                        out_status_next = tcpq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        mem_re            = 1'b1;
                        cnt_next[rem_idx] = cnt_reg[rem_idx] - CW'(1);
                        rp_next[rem_idx]  = (rp_reg[rem_idx] == PW'(CLASS_DEPTH - 1))
                                            ? '0 : rp_reg[rem_idx] + PW'(1);
                        state_next        = S_READ;
                    end
                end
            end
            S_READ:
            begin
                out_valid_next  = 1'b1;
                out_value_next  = rd_data_reg;
                out_status_next = tcpq_pkg::STATUS_DONE;
                state_next      = S_RUN;
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_RUN;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= tcpq_pkg::STATUS_DONE;
            for (int i = 0; i < NC; i++)
            begin
                rp_reg[i]  <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            rp_reg         <= rp_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= cmd.value;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.removed_value = out_value_reg;
    assign rsp.status        = out_status_reg;

endmodule

@@ hw/rtl/three_class_priority_queue_core.sv @@
// top level of the three-class strict-priority queue
// requests come in on req: mode 0 inserts priority_value, mode 1 removes
// the oldest value of the highest non-empty class (high, middle, low).
// each request gives one response on rsp: removed_value and status
// (done, queue empty on remove, class store full on insert).
// thresholds are set through cfg_we/cfg_index/cfg_data while idle:
// index 0 high threshold, index 1 middle threshold.
// the front end classifies a request and puts it in a two-entry queue;
// the back end works on it against the class stores.
// a request is registered in the queue entry, then in the result register,
// before its response; a successful remove also passes the S_READ state.
// throughput: one insert per cycle while rsp is ready; a successful remove
// holds the back end in S_READ for the registered read of the class store.
// reset sets thresholds to 50 and 30 and empties all classes.
// a stalled rsp holds its response; two more requests queue up behind it
// before req.ready drops.
module three_class_priority_queue_core
#(
    parameter int CLASS_DEPTH = tcpq_pkg::CLASS_DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tcpq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcpq_pkg::CFG_DATA_W-1:0]     cfg_data,
    tcpq_req_if.sink                            req,
    tcpq_rsp_if.source                          rsp
);

    logic           push_valid;
    logic           push_ready;
    tcpq_pkg::cmd_t push_cmd;
    logic           pop_valid;
    logic           pop_ready;
    tcpq_pkg::cmd_t pop_cmd;

    tcpq_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    tcpq_cmd_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    tcpq_back
    #(
        .CLASS_DEPTH (CLASS_DEPTH)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .rsp       (rsp)
    );

endmodule
